// ===== sv/tlvr_pkg.sv =====
`default_nettype none
package tlvr_pkg;

  // Field and angle resolution
  localparam int unsigned CoordBits = 16;
  localparam int unsigned AngleBits = 16;
  localparam int unsigned GuardBits = 16;
  localparam int unsigned TableLen  = 24;

  // Datapath widths: guarded coordinates plus CORDIC growth and sign
  localparam int unsigned VecW  = CoordBits + GuardBits + 4;
  localparam int unsigned RotZW = 34;

  // 1/K with 32 fraction bits
  localparam logic [31:0] GainQ32 = 32'h9B74EDA9;

  // Register map
  localparam logic [0:0] RegMaxTurn   = 1'b0;
  localparam logic [15:0] MaxTurnReset = 16'd2048;

  typedef struct packed {
    logic signed [CoordBits-1:0] origin_x;
    logic signed [CoordBits-1:0] origin_y;
    logic signed [CoordBits-1:0] target_x;
    logic signed [CoordBits-1:0] target_y;
  } in_word_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] new_x;
    logic signed [CoordBits-1:0] new_y;
  } out_word_t;

  // Pipeline control that travels between the sections
  typedef struct packed {
    logic en;
    logic valid;
  } pipe_ctl_t;

  // Arctangent of 2^-i in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input int unsigned idx);
    logic [31:0] r;
    case (idx)
      0:  r = 32'h20000000;
      1:  r = 32'h12E4051E;
      2:  r = 32'h09FB385B;
      3:  r = 32'h051111D4;
      4:  r = 32'h028B0D43;
      5:  r = 32'h0145D7E1;
      6:  r = 32'h00A2F61E;
      7:  r = 32'h00517C55;
      8:  r = 32'h0028BE53;
      9:  r = 32'h00145F2F;
      10: r = 32'h000A2F98;
      11: r = 32'h000517CC;
      12: r = 32'h00028BE6;
      13: r = 32'h000145F3;
      14: r = 32'h0000A2FA;
      15: r = 32'h0000517D;
      16: r = 32'h000028BE;
      17: r = 32'h0000145F;
      18: r = 32'h00000A30;
      19: r = 32'h00000518;
      20: r = 32'h0000028C;
      21: r = 32'h00000146;
      22: r = 32'h000000A3;
      23: r = 32'h00000051;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/tlvr_vec_cordic.sv =====
`default_nettype none
module tlvr_vec_cordic import tlvr_pkg::*; #(
  parameter int unsigned NUM_ITER = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire pipe_ctl_t                   ctl_i,
  input  wire logic signed [CoordBits-1:0] x_i,
  input  wire logic signed [CoordBits-1:0] y_i,
  output logic                             valid_o,
  output logic [31:0]                      angle_o
);

  logic signed [VecW-1:0] x_q    [NUM_ITER+1];
  logic signed [VecW-1:0] y_q    [NUM_ITER+1];
  logic        [31:0]     z_q    [NUM_ITER+1];
  logic                   zero_q [NUM_ITER+1];
  logic                   vld_q  [NUM_ITER+1];

  logic signed [VecW-1:0] x_ext, y_ext, x0_d, y0_d;
  logic        [31:0]     z0_d;

  // Fold the left half plane onto the right and add guard bits
  always_comb begin
    x_ext = VecW'(x_i);
    y_ext = VecW'(y_i);
    z0_d  = 32'h0;
    if (x_i < 0) begin
      x_ext = -x_ext;
      y_ext = -y_ext;
      z0_d  = 32'h80000000;
    end
    x0_d = x_ext <<< GuardBits;
    y0_d = y_ext <<< GuardBits;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (ctl_i.en) begin
      vld_q[0] <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      x_q[0]    <= x0_d;
      y_q[0]    <= y0_d;
      z_q[0]    <= z0_d;
      zero_q[0] <= (x_i == '0) && (y_i == '0);
    end
  end

  // One micro-rotation per stage, driving y toward zero
  for (genvar i = 0; i < NUM_ITER; i++) begin : g_iter
    logic signed [VecW-1:0] x_d, y_d;
    logic        [31:0]     z_d;

    always_comb begin
      if (y_q[i] < 0) begin
        x_d = x_q[i] - (y_q[i] >>> i);
        y_d = y_q[i] + (x_q[i] >>> i);
        z_d = z_q[i] - atan_turn(i);
      end else begin
        x_d = x_q[i] + (y_q[i] >>> i);
        y_d = y_q[i] - (x_q[i] >>> i);
        z_d = z_q[i] + atan_turn(i);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else if (ctl_i.en) begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        x_q[i+1]    <= x_d;
        y_q[i+1]    <= y_d;
        z_q[i+1]    <= z_d;
        zero_q[i+1] <= zero_q[i];
      end
    end
  end

  // A zero vector has angle zero
  assign valid_o = vld_q[NUM_ITER];
  assign angle_o = zero_q[NUM_ITER] ? 32'h0 : z_q[NUM_ITER];

endmodule
`default_nettype wire

// ===== sv/tlvr_turn_limit.sv =====
`default_nettype none
module tlvr_turn_limit import tlvr_pkg::*; (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire pipe_ctl_t                   ctl_i,
  input  wire logic [31:0]                 angle_t_i,
  input  wire logic [31:0]                 angle_o_i,
  input  wire logic signed [CoordBits-1:0] ox_i,
  input  wire logic signed [CoordBits-1:0] oy_i,
  input  wire logic [15:0]                 max_turn_i,
  output logic                             valid_o,
  output logic signed [VecW-1:0]           x_o,
  output logic signed [VecW-1:0]           y_o,
  output logic signed [RotZW-1:0]          z_o
);

  localparam int unsigned ProdW = CoordBits + 1 + 33;
  localparam logic [31:0] AngRound = 32'(1) << (31 - AngleBits);
  localparam logic [AngleBits:0] Half = (AngleBits+1)'(1) << (AngleBits - 1);
  localparam logic signed [ProdW-1:0] ProdRound = ProdW'(1) <<< (31 - GuardBits);
  localparam logic signed [32:0] GainS = $signed({1'b0, GainQ32});

  // ---------------- stage 1: wrap and clamp the turn ----------------
  logic [31:0]              diff;
  logic signed [AngleBits:0] v_s, lim_s, v_c;
  logic [AngleBits:0]       lim;
  logic [31:0]              r;
  logic                     flip_d;
  logic [31:0]              z1_d;

  always_comb begin
    diff = angle_t_i - angle_o_i + AngRound;
    v_s  = $signed({diff[31], diff[31 -: AngleBits]});
    lim  = ((AngleBits+1)'(max_turn_i) > Half) ? Half : (AngleBits+1)'(max_turn_i);
    lim_s = $signed(lim);
    v_c = v_s;
    if (v_s > lim_s) begin
      v_c = lim_s;
    end
    if (v_s < -lim_s) begin
      v_c = -lim_s;
    end
    r = {v_c[AngleBits-1:0], {(32-AngleBits){1'b0}}};
    // Turns past a quarter rotate the negated vector by the rest
    flip_d = r[31] ^ r[30];
    z1_d   = flip_d ? {~r[31], r[30:0]} : r;
  end

  logic                        vld1_q, vld2_q, vld3_q;
  logic                        flip1_q;
  logic [31:0]                 z1_q, z2_q;
  logic signed [CoordBits-1:0] ox1_q, oy1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else if (ctl_i.en) begin
      vld1_q <= ctl_i.valid;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      flip1_q <= flip_d;
      z1_q    <= z1_d;
      ox1_q   <= ox_i;
      oy1_q   <= oy_i;
    end
  end

  // ---------------- stage 2: negate and apply gain ----------------
  logic signed [CoordBits:0] xn, yn;
  logic signed [ProdW-1:0]   px_d, py_d, px_q, py_q;

  always_comb begin
    xn = flip1_q ? -(CoordBits+1)'(ox1_q) : (CoordBits+1)'(ox1_q);
    yn = flip1_q ? -(CoordBits+1)'(oy1_q) : (CoordBits+1)'(oy1_q);
    px_d = ProdW'(xn) * ProdW'(GainS);
    py_d = ProdW'(yn) * ProdW'(GainS);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      px_q <= px_d;
      py_q <= py_d;
      z2_q <= z1_q;
    end
  end

  // ---------------- stage 3: round to guard-bit fraction ----------------
  logic signed [ProdW-1:0] rx, ry;
  logic signed [VecW-1:0]  x3_q, y3_q;
  logic signed [RotZW-1:0] z3_q;

  always_comb begin
    rx = (px_q + ProdRound) >>> (32 - GuardBits);
    ry = (py_q + ProdRound) >>> (32 - GuardBits);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      x3_q <= rx[VecW-1:0];
      y3_q <= ry[VecW-1:0];
      z3_q <= RotZW'($signed(z2_q));
    end
  end

  assign valid_o = vld3_q;
  assign x_o     = x3_q;
  assign y_o     = y3_q;
  assign z_o     = z3_q;

endmodule
`default_nettype wire

// ===== sv/tlvr_rot_cordic.sv =====
`default_nettype none
module tlvr_rot_cordic import tlvr_pkg::*; #(
  parameter int unsigned NUM_ITER = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire pipe_ctl_t              ctl_i,
  input  wire logic signed [VecW-1:0]  x_i,
  input  wire logic signed [VecW-1:0]  y_i,
  input  wire logic signed [RotZW-1:0] z_i,
  output logic                        valid_o,
  output out_word_t                   data_o
);

  localparam logic signed [VecW-1:0] OutRound = VecW'(1) <<< (GuardBits - 1);
  localparam int unsigned RW = VecW - GuardBits;
  localparam logic signed [RW-1:0] SatHi = RW'((1 << (CoordBits - 1)) - 1);
  localparam logic signed [RW-1:0] SatLo = -RW'(1 << (CoordBits - 1));

  logic signed [VecW-1:0]  x_q   [1:NUM_ITER];
  logic signed [VecW-1:0]  y_q   [1:NUM_ITER];
  logic signed [RotZW-1:0] z_q   [1:NUM_ITER];
  logic                    vld_q [1:NUM_ITER];

  // One micro-rotation per stage, driving z toward zero
  for (genvar i = 0; i < NUM_ITER; i++) begin : g_iter
    logic signed [VecW-1:0]  x_s, y_s, x_d, y_d;
    logic signed [RotZW-1:0] z_s, z_d, a_s;
    logic                    vld_s;

    // Stage zero is the turn limiter's output register
    if (i == 0) begin : g_head
      assign x_s   = x_i;
      assign y_s   = y_i;
      assign z_s   = z_i;
      assign vld_s = ctl_i.valid;
    end else begin : g_tail
      assign x_s   = x_q[i];
      assign y_s   = y_q[i];
      assign z_s   = z_q[i];
      assign vld_s = vld_q[i];
    end

    always_comb begin
      a_s = $signed({{(RotZW-32){1'b0}}, atan_turn(i)});
      if (z_s >= 0) begin
        x_d = x_s - (y_s >>> i);
        y_d = y_s + (x_s >>> i);
        z_d = z_s - a_s;
      end else begin
        x_d = x_s + (y_s >>> i);
        y_d = y_s - (x_s >>> i);
        z_d = z_s + a_s;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else if (ctl_i.en) begin
        vld_q[i+1] <= vld_s;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        x_q[i+1] <= x_d;
        y_q[i+1] <= y_d;
        z_q[i+1] <= z_d;
      end
    end
  end

  // Round half up to integer and saturate
  logic signed [VecW-1:0] xr, yr;
  logic signed [RW-1:0]   xi, yi;
  out_word_t              out_d, out_q;
  logic                   out_vld_q;

  always_comb begin
    xr = (x_q[NUM_ITER] + OutRound) >>> GuardBits;
    yr = (y_q[NUM_ITER] + OutRound) >>> GuardBits;
    xi = xr[RW-1:0];
    yi = yr[RW-1:0];
    if (xi > SatHi) begin
      out_d.new_x = SatHi[CoordBits-1:0];
    end else if (xi < SatLo) begin
      out_d.new_x = SatLo[CoordBits-1:0];
    end else begin
      out_d.new_x = xi[CoordBits-1:0];
    end
    if (yi > SatHi) begin
      out_d.new_y = SatHi[CoordBits-1:0];
    end else if (yi < SatLo) begin
      out_d.new_y = SatLo[CoordBits-1:0];
    end else begin
      out_d.new_y = yi[CoordBits-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (ctl_i.en) begin
      out_vld_q <= vld_q[NUM_ITER];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      out_q <= out_d;
    end
  end

  assign valid_o = out_vld_q;
  assign data_o  = out_q;

endmodule
`default_nettype wire

// ===== sv/turn_limited_vector_rotation_core.sv =====
`default_nettype none
// Turn-rate limited vector rotation. Each input word carries a heading
// (origin) and a desired direction (target) in signed Q8.8; the result word
// is the heading rotated toward the target by at most max_turn (binary angle,
// 32768 = pi), rounded and saturated to Q8.8. The block accepts one word per
// clock unless the output stalls, and holds no state between words. N is
// CORDIC_STAGES capped at 24: one prepare stage and N vectoring stages that
// find both angles side by side, three stages that clamp the turn and apply
// the CORDIC gain, N rotation stages and the output register. The pipeline
// advances whenever the output register is empty or its word is taken, so a
// stalled output holds every stage. max_turn sits at APB byte address 0,
// resets to 2048; the user must write it only while idle (not enforced).
module turn_limited_vector_rotation_core import tlvr_pkg::*; #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire in_word_t    in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output out_word_t        out_data_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned NumIter = (CORDIC_STAGES < TableLen) ? CORDIC_STAGES : TableLen;

  // ---------------- configuration register ----------------
  logic [15:0] max_turn_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_turn_q <= MaxTurnReset;
    end else if (psel && penable && pwrite && (paddr[2:2] == RegMaxTurn)) begin
      max_turn_q <= pwdata[15:0];
    end
  end

  always_comb begin
    prdata = 32'h0;
    if (paddr[2:2] == RegMaxTurn) begin
      prdata = {16'h0, max_turn_q};
    end
  end

  // ---------------- pipeline advance ----------------
  logic      advance;
  pipe_ctl_t ctl_in, ctl_lim, ctl_rot;

  assign advance    = !out_valid_o || out_ready_i;
  assign in_ready_o = advance;
  assign ctl_in     = '{en: advance, valid: in_valid_i};

  // ---------------- angle of both vectors ----------------
  logic        vld_o, vld_t;
  logic [31:0] ang_o, ang_t;

  tlvr_vec_cordic #(.NUM_ITER(NumIter)) u_vec_origin (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl_in),
    .x_i     (in_data_i.origin_x),
    .y_i     (in_data_i.origin_y),
    .valid_o (vld_o),
    .angle_o (ang_o)
  );

  tlvr_vec_cordic #(.NUM_ITER(NumIter)) u_vec_target (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl_in),
    .x_i     (in_data_i.target_x),
    .y_i     (in_data_i.target_y),
    .valid_o (vld_t),
    .angle_o (ang_t)
  );

  // Hold the origin alongside the vectoring stages
  logic signed [CoordBits-1:0] ox_dly_q [NumIter+1];
  logic signed [CoordBits-1:0] oy_dly_q [NumIter+1];

  always_ff @(posedge clk_i) begin
    if (advance) begin
      ox_dly_q[0] <= in_data_i.origin_x;
      oy_dly_q[0] <= in_data_i.origin_y;
      for (int unsigned k = 1; k <= NumIter; k++) begin
        ox_dly_q[k] <= ox_dly_q[k-1];
        oy_dly_q[k] <= oy_dly_q[k-1];
      end
    end
  end

  assign ctl_lim = '{en: advance, valid: vld_o && vld_t};

  // ---------------- clamp turn, gain compensation ----------------
  logic                    vld_l;
  logic signed [VecW-1:0]  lx, ly;
  logic signed [RotZW-1:0] lz;

  tlvr_turn_limit u_limit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl_lim),
    .angle_t_i  (ang_t),
    .angle_o_i  (ang_o),
    .ox_i       (ox_dly_q[NumIter]),
    .oy_i       (oy_dly_q[NumIter]),
    .max_turn_i (max_turn_q),
    .valid_o    (vld_l),
    .x_o        (lx),
    .y_o        (ly),
    .z_o        (lz)
  );

  assign ctl_rot = '{en: advance, valid: vld_l};

  // ---------------- rotate heading ----------------
  tlvr_rot_cordic #(.NUM_ITER(NumIter)) u_rot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl_rot),
    .x_i     (lx),
    .y_i     (ly),
    .z_i     (lz),
    .valid_o (out_valid_o),
    .data_o  (out_data_o)
  );

endmodule
`default_nettype wire

// ===== dv/tb_turn_limited_vector_rotation_core.sv =====
`timescale 1ns / 100ps
module tb_turn_limited_vector_rotation_core;
  import tlvr_pkg::*;

  localparam int Stages  = 16;
  localparam int Latency = 2 * Stages + 5;

  // One accepted word together with what it should turn into
  typedef struct packed {
    in_word_t    src;
    logic [15:0] limit;
    out_word_t   heading;
  } turn_case_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  in_word_t    in_data_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_word_t   out_data_o;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [2:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;

  // Predictor state and scoreboard
  logic [15:0] turn_limit = MaxTurnReset;
  turn_case_t  pending_turns [$];
  turn_case_t  oldest_turn;
  int          mismatch_count = 0;
  int          words_sent     = 0;
  int          words_checked  = 0;
  int          limits_written = 0;
  int          stall_left     = 0;
  bit          in_idle        = 1'b1;
  bit          out_idle       = 1'b1;

  // Arctangent of 2^-i, in 2^-32 turn
  bit [31:0] arc_turn [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  turn_limited_vector_rotation_core #(
    .CORDIC_STAGES(Stages)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Bearing of a vector by CORDIC vectoring; a zero vector has bearing zero
  function automatic bit [31:0] bearing_of(longint x, longint y);
    bit [31:0] z;
    longint    dx, dy;
    int        i;
    z = '0;
    if (x == 0 && y == 0) return '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h8000_0000;
    end
    x = x <<< GuardBits;
    y = y <<< GuardBits;
    for (i = 0; i < Stages && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y < 0) begin
        x = x - dx;
        y = y + dy;
        z = z - arc_turn[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + arc_turn[i];
      end
    end
    return z;
  endfunction

  // Apply 1/K and round to the guard fraction
  function automatic longint gain_scale(longint v);
    longint p;
    p = v * longint'(GainQ32);
    return (p + (64'sd1 <<< (31 - GuardBits))) >>> (32 - GuardBits);
  endfunction

  // Round half up to an integer coordinate and saturate
  function automatic logic [CoordBits-1:0] round_to_coord(longint v);
    longint r, top;
    top = (64'sd1 <<< (CoordBits - 1)) - 1;
    r = (v + (64'sd1 <<< (GuardBits - 1))) >>> GuardBits;
    if (r > top) r = top;
    if (r < -top - 1) r = -top - 1;
    return r[CoordBits-1:0];
  endfunction

  // Turn the origin toward the target by at most the limit
  function automatic out_word_t predict_heading(in_word_t w, logic [15:0] limit);
    bit [31:0] diff, rot;
    longint    half, lim, turn, shifted, x, y, z, dx, dy;
    out_word_t res;
    int        i;
    diff = bearing_of(longint'($signed(w.target_x)), longint'($signed(w.target_y)))
         - bearing_of(longint'($signed(w.origin_x)), longint'($signed(w.origin_y)));
    diff = diff + (32'd1 << (31 - AngleBits));
    turn = longint'(diff >> (32 - AngleBits));
    half = 64'sd1 <<< (AngleBits - 1);
    if (turn >= half) turn = turn - 2 * half;
    lim = longint'(limit);
    if (lim > half) lim = half;
    if (turn > lim) turn = lim;
    if (turn < -lim) turn = -lim;
    shifted = turn <<< (32 - AngleBits);
    rot = shifted[31:0];
    x = longint'($signed(w.origin_x));
    y = longint'($signed(w.origin_y));
    // Fold turns past a quarter into a half-turn flip
    if (rot >= 32'h4000_0000 && rot < 32'hC000_0000) begin
      x = -x;
      y = -y;
      rot = rot - 32'h8000_0000;
    end
    z = longint'($signed(rot));
    x = gain_scale(x);
    y = gain_scale(y);
    for (i = 0; i < Stages && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - longint'(arc_turn[i]);
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + longint'(arc_turn[i]);
      end
    end
    res.new_x = round_to_coord(x);
    res.new_y = round_to_coord(y);
    return res;
  endfunction

  // Idle length: mostly none, some short, a few long
  function automatic int pick_gap(bit enabled);
    int roll;
    if (!enabled) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] nudge(int span);
    logic [31:0] r;
    r = $urandom_range(0, 2 * span) - span;
    return r[15:0];
  endfunction

  function automatic logic [15:0] corner_coord();
    case ($urandom_range(0, 6))
      0:       return 16'h8000;
      1:       return 16'h8001;
      2:       return 16'hFFFF;
      3:       return 16'h0000;
      4:       return 16'h0001;
      5:       return 16'h7FFE;
      default: return 16'h7FFF;
    endcase
  endfunction

  function automatic in_word_t vector_pair(int ox, int oy, int tx, int ty);
    in_word_t w;
    w.origin_x = ox[15:0];
    w.origin_y = oy[15:0];
    w.target_x = tx[15:0];
    w.target_y = ty[15:0];
    return w;
  endfunction

  // Random heading/target pair: full range, scaled, near-aligned, opposed, corners, zero
  function automatic in_word_t random_heading_pair();
    in_word_t    w;
    logic [31:0] a, b;
    int          span;
    a = $urandom();
    b = $urandom();
    w = {a, b};
    span = 1 << $urandom_range(4, 15);
    case ($urandom_range(0, 9))
      2, 3, 4: begin
        w.origin_x = nudge(span);
        w.origin_y = nudge(span);
        w.target_x = nudge(span);
        w.target_y = nudge(span);
      end
      5, 6: begin
        w.origin_x = nudge(span);
        w.origin_y = nudge(span);
        w.target_x = w.origin_x + nudge(span / 8);
        w.target_y = w.origin_y + nudge(span / 8);
      end
      7: begin
        w.origin_x = nudge(span);
        w.origin_y = nudge(span);
        w.target_x = -w.origin_x + nudge(2);
        w.target_y = -w.origin_y + nudge(2);
      end
      8: begin
        w.origin_x = corner_coord();
        w.origin_y = corner_coord();
        w.target_x = corner_coord();
        w.target_y = corner_coord();
      end
      9: begin
        if ($urandom_range(0, 1) == 0) begin
          w.origin_x = '0;
          w.origin_y = '0;
        end else begin
          w.target_x = '0;
          w.target_y = '0;
        end
      end
      default: ;
    endcase
    return w;
  endfunction

  // Send one word and record its expected heading on acceptance
  task automatic send_heading(in_word_t w);
    int         gap;
    turn_case_t tc;
    gap = pick_gap(in_idle);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    tc.src     = w;
    tc.limit   = turn_limit;
    tc.heading = predict_heading(w, turn_limit);
    pending_turns.push_back(tc);
    words_sent++;
  endtask

  // Drop valid and hold until every expected word is back
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_turns.size() != 0);
  endtask

  // APB write of max_turn: setup cycle, then access
  task automatic write_turn_limit(logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {RegMaxTurn, 2'b00};
    pwdata  <= {16'h0000, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    turn_limit = value;
    limits_written++;
  endtask

  // Check each delivered word and pace the output side
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_turns.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected word (%0d,%0d) with nothing pending",
                   out_data_o.new_x, out_data_o.new_y);
      end else begin
        oldest_turn = pending_turns.pop_front();
        if (out_data_o.new_x !== oldest_turn.heading.new_x ||
            out_data_o.new_y !== oldest_turn.heading.new_y) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("word %0d o=(%0d,%0d) t=(%0d,%0d) lim=%0d: expected (%0d,%0d) got (%0d,%0d)",
                     words_checked, oldest_turn.src.origin_x, oldest_turn.src.origin_y,
                     oldest_turn.src.target_x, oldest_turn.src.target_y, oldest_turn.limit,
                     oldest_turn.heading.new_x, oldest_turn.heading.new_y,
                     out_data_o.new_x, out_data_o.new_y);
        end
        words_checked++;
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      stall_left = pick_gap(out_idle);
      out_ready_i <= (stall_left == 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // Axis turns, half turn, zero vectors, field extremes and saturation
  task automatic test_directed_extremes();
    in_word_t cases [13];
    int       k;
    cases[0]  = vector_pair(256, 0, 0, 256);
    cases[1]  = vector_pair(256, 0, 0, -256);
    cases[2]  = vector_pair(256, 0, -256, 0);
    cases[3]  = vector_pair(0, 0, 100, 50);
    cases[4]  = vector_pair(300, -200, 0, 0);
    cases[5]  = vector_pair(0, 0, 0, 0);
    cases[6]  = vector_pair(-32768, -32768, 32767, 32767);
    cases[7]  = vector_pair(32767, 32767, -32768, 32767);
    cases[8]  = vector_pair(-32768, 0, -32768, 1);
    cases[9]  = vector_pair(256, 10, 256, 20);
    cases[10] = vector_pair(-1, -1, 1, -1);
    cases[11] = vector_pair(32767, -32768, -32768, -32768);
    cases[12] = vector_pair(0, 32767, 0, -32768);
    // Reset limit first, so the reset value is exercised
    for (k = 0; k < 13; k++) send_heading(cases[k]);
    // Limit above pi behaves as pi
    wait_for_drain();
    write_turn_limit(16'hFFFF);
    send_heading(cases[0]);
    send_heading(cases[2]);
    send_heading(cases[6]);
    send_heading(cases[12]);
    wait_for_drain();
    write_turn_limit(16'd32768);
    send_heading(cases[2]);
    send_heading(cases[12]);
    // Zero limit: heading must not turn
    wait_for_drain();
    write_turn_limit(16'd0);
    send_heading(cases[0]);
    send_heading(cases[9]);
  endtask

  // Random words under a series of limits, extremes included
  task automatic test_limit_sweep();
    logic [15:0] fixed_limits [7];
    logic [15:0] value;
    logic [31:0] r;
    int          phase;
    fixed_limits = '{16'd0, 16'd1, 16'd2048, 16'd16384, 16'd32767, 16'd32768, 16'hFFFF};
    for (phase = 0; phase < 10; phase++) begin
      if (phase < 7) begin
        value = fixed_limits[phase];
      end else begin
        r = $urandom();
        value = r[15:0];
      end
      wait_for_drain();
      write_turn_limit(value);
      repeat (140) send_heading(random_heading_pair());
    end
  endtask

  // Full-rate bursts, with one pause until the pipe is empty
  task automatic test_back_to_back();
    in_idle  = 1'b0;
    out_idle = 1'b0;
    repeat (80) send_heading(random_heading_pair());
    wait_for_drain();
    repeat (70) send_heading(random_heading_pair());
    in_idle  = 1'b1;
    out_idle = 1'b1;
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_extremes();
    test_limit_sweep();
    test_back_to_back();
    wait_for_drain();
    repeat (Latency + 8) @(posedge clk_i);
    $display("Sent %0d words, checked %0d, under %0d turn-limit writes plus reset value.",
             words_sent, words_checked, limits_written);
    $display("Covered zero vectors, half turns, limits 0 to above pi, saturation; %0d mismatches.",
             mismatch_count);
    if (mismatch_count == 0 && pending_turns.size() == 0) begin
      $display("tb_turn_limited_vector_rotation_core: PASS");
    end else begin
      $display("tb_turn_limited_vector_rotation_core: FAIL");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #2000000;
    $display("timed out with %0d words pending", pending_turns.size());
    $display("tb_turn_limited_vector_rotation_core: FAIL");
    $finish;
  end

endmodule
